>>> rtl/core/tarl_pkg.sv
package tarl_pkg;

   localparam int RING_FRAMES_DEF       = 4096;
   localparam int MAX_CHANNELS_DEF      = 8;
   localparam int MAX_BLOCK_SAMPLES_DEF = 4096;

   localparam int FRAME_W = 48;
   localparam int IDX_W   = 12;
   localparam int BLK_W   = 13;
   localparam int WORD_W  = 32;
   localparam int CH_W    = 4;
   localparam int SUM_W   = FRAME_W + 1;

   localparam int REQ_TDATA_W = 112;

   localparam logic [CH_W-1:0] CH_RESET = 4'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam int STEP_BITS = 8;
   localparam int DVD_W     = 16;
   localparam int MOD_ITER  = FRAME_W / STEP_BITS;
   localparam int DIV_ITER  = DVD_W / STEP_BITS;
   localparam int ITER_W    = $clog2(MOD_ITER);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_MUL,
      ST_RED,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic calc_t;
      logic reduce;
      logic access;
      logic out_load;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic is_read;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/timestamped_audio_loopback_ring.sv
// Channel   Direction  Signals                                Moves
// req_      in         tvalid tready tdata[111:0] tuser tlast  one sample transaction
// rsp_      out        tvalid tready tdata[31:0] tuser         one read result
// csr_      in         wen wdata[3:0]                          channel count write
//
// After acceptance frame_time is reduced modulo RING_FRAMES eight bits at a time,
// then come the address multiply, the ring wrap, the store access and, for a
// read, the output load, which waits out any rsp_ stall. After reset the store,
// all RING_FRAMES*MAX_CHANNELS words, is swept to zero with req_tready low. A held
// result does not block acceptance of the next request.
module timestamped_audio_loopback_ring #(
   parameter int RING_FRAMES       = tarl_pkg::RING_FRAMES_DEF,
   parameter int MAX_CHANNELS      = tarl_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_BLOCK_SAMPLES = tarl_pkg::MAX_BLOCK_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // frame_time, sample_index, block_samples, sample_value, zero pad
   input  logic [tarl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value
   output logic [tarl_pkg::WORD_W-1:0]      rsp_tdata,
   // silenced
   output logic                             rsp_tuser,
   input  logic                             csr_wen,
   input  logic [tarl_pkg::CH_W-1:0]        csr_wdata
);

   tarl_pkg::cmd_type    cmd;
   tarl_pkg::status_type status;

   tarl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   tarl_dp #(
      .RING_FRAMES       (RING_FRAMES),
      .MAX_CHANNELS      (MAX_CHANNELS),
      .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_command       (req_tuser),
      .in_frame_time    (req_tdata[47:0]),
      .in_sample_index  (req_tdata[59:48]),
      .in_block_samples (req_tdata[72:60]),
      .in_sample_value  (req_tdata[104:73]),
      .in_last_in_block (req_tlast),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule

>>> rtl/core/tarl_ram.sv
module tarl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/tarl_ctrl.sv
module tarl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tarl_pkg::status_type status,
   output tarl_pkg::cmd_type    cmd
);

   tarl_pkg::state_type state_ff;
   tarl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tarl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         tarl_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               state_in = tarl_pkg::ST_IDLE;
            end
         end
         tarl_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = tarl_pkg::ST_MOD;
            end
         end
         tarl_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = tarl_pkg::ST_MUL;
            end
         end
         tarl_pkg::ST_MUL: begin
            cmd.calc_t = 1'b1;
            state_in   = tarl_pkg::ST_RED;
         end
         tarl_pkg::ST_RED: begin
            cmd.reduce = 1'b1;
            state_in   = tarl_pkg::ST_ACC;
         end
         tarl_pkg::ST_ACC: begin
            cmd.access = 1'b1;
            if (status.is_read) begin
               state_in = tarl_pkg::ST_OUT;
            end else begin
               state_in = tarl_pkg::ST_IDLE;
            end
         end
         tarl_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tarl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tarl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/tarl_dp.sv
module tarl_dp #(
   parameter int RING_FRAMES       = tarl_pkg::RING_FRAMES_DEF,
   parameter int MAX_CHANNELS      = tarl_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_BLOCK_SAMPLES = tarl_pkg::MAX_BLOCK_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tarl_pkg::cmd_type            cmd,
   output tarl_pkg::status_type         status,
   input  logic                         in_command,
   input  logic [tarl_pkg::FRAME_W-1:0] in_frame_time,
   input  logic [tarl_pkg::IDX_W-1:0]   in_sample_index,
   input  logic [tarl_pkg::BLK_W-1:0]   in_block_samples,
   input  logic [tarl_pkg::WORD_W-1:0]  in_sample_value,
   input  logic                         in_last_in_block,
   input  logic                         csr_wen,
   input  logic [tarl_pkg::CH_W-1:0]    csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tarl_pkg::WORD_W-1:0]  rsp_tdata,
   output logic                         rsp_tuser
);

   localparam int REM_W  = $clog2(RING_FRAMES);
   localparam int T_W    = REM_W + 5;
   localparam int QB     = $clog2((1 << tarl_pkg::IDX_W) / RING_FRAMES + 2);
   localparam int RED_W  = T_W + QB;
   localparam int DEPTH  = RING_FRAMES * MAX_CHANNELS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CHK_W  = 17;

   localparam logic [REM_W:0]   RF_EXT    = (REM_W + 1)'(RING_FRAMES);
   localparam logic [CHK_W-1:0] MAX_BLK_X = CHK_W'(MAX_BLOCK_SAMPLES);
   localparam logic [9:0]       MAX_CH_X  = 10'(MAX_CHANNELS);

   logic [tarl_pkg::CH_W-1:0] chan_ff;
   logic [tarl_pkg::CH_W-1:0] ch_act;

   logic                            cmd_ff;
   logic [tarl_pkg::FRAME_W-1:0]    frame_ff;
   logic [tarl_pkg::IDX_W-1:0]      idx_ff;
   logic [tarl_pkg::WORD_W-1:0]     word_ff;
   logic                            last_ff;
   logic [tarl_pkg::CH_W-1:0]       ch_ff;
   logic [tarl_pkg::FRAME_W-1:0]    sh_ff;
   logic [REM_W-1:0]                frem_ff;
   logic [REM_W-1:0]                frem_in;
   logic [tarl_pkg::DVD_W-1:0]      dvd_ff;
   logic [tarl_pkg::CH_W-1:0]       drem_ff;
   logic [tarl_pkg::CH_W-1:0]       drem_in;
   logic [tarl_pkg::DVD_W-1:0]      q_ff;
   logic [tarl_pkg::DVD_W-1:0]      q_in;
   logic [tarl_pkg::ITER_W-1:0]     iter_ff;
   logic [T_W-1:0]                  t_ff;
   logic [tarl_pkg::SUM_W-1:0]      sum_ff;
   logic [ADDR_W-1:0]               addr_ff;
   logic [ADDR_W-1:0]               addr_in;
   logic                            sil_ff;
   logic [tarl_pkg::SUM_W-1:0]      lwf_ff;
   logic [ADDR_W-1:0]               clr_ff;
   logic                            rsp_valid_ff;
   logic [tarl_pkg::WORD_W-1:0]     rsp_data_ff;
   logic                            rsp_user_ff;
   logic [tarl_pkg::BLK_W-1:0]      blk_sat;

   logic [ADDR_W-1:0]               ram_addr;
   logic                            ram_we;
   logic                            ram_re;
   logic [tarl_pkg::WORD_W-1:0]     ram_wdata;
   logic [tarl_pkg::WORD_W-1:0]     ram_rdata;

   always_comb begin
      ch_act = chan_ff;
      if (chan_ff == '0) begin
         ch_act = tarl_pkg::CH_W'(1);
      end else if ({6'd0, chan_ff} > MAX_CH_X) begin
         ch_act = tarl_pkg::CH_W'(MAX_CHANNELS);
      end
   end

   always_comb begin
      blk_sat = in_block_samples;
      if ({4'd0, in_block_samples} > MAX_BLK_X) begin
         blk_sat = tarl_pkg::BLK_W'(MAX_BLOCK_SAMPLES);
      end
   end

   always_comb begin
      logic [REM_W:0]            ftmp;
      logic [REM_W-1:0]          fr;
      logic [tarl_pkg::CH_W:0]   dtmp;
      logic [tarl_pkg::CH_W-1:0] dr;
      logic [tarl_pkg::DVD_W-1:0] qq;
      logic                      qbit;
      fr = frem_ff;
      dr = drem_ff;
      qq = q_ff;
      for (int i = 0; i < tarl_pkg::STEP_BITS; i++) begin
         ftmp = {fr, sh_ff[tarl_pkg::FRAME_W-1-i]};
         if (ftmp >= RF_EXT) begin
            ftmp = ftmp - RF_EXT;
         end
         fr = ftmp[REM_W-1:0];
         dtmp = {dr, dvd_ff[tarl_pkg::DVD_W-1-i]};
         qbit = (dtmp >= {1'b0, ch_ff});
         if (qbit) begin
            dtmp = dtmp - {1'b0, ch_ff};
         end
         dr = dtmp[tarl_pkg::CH_W-1:0];
         qq = {qq[tarl_pkg::DVD_W-2:0], qbit};
      end
      frem_in = fr;
      drem_in = dr;
      q_in    = qq;
   end

   always_comb begin
      logic [RED_W-1:0] r;
      logic [RED_W-1:0] span;
      r    = RED_W'(t_ff);
      span = RED_W'(RING_FRAMES) * RED_W'(ch_ff);
      for (int k = QB - 1; k >= 0; k--) begin
         if (r >= (span << k)) begin
            r = r - (span << k);
         end
      end
      addr_in = ADDR_W'(r);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= in_command;
         frame_ff <= in_frame_time;
         idx_ff   <= in_sample_index;
         word_ff  <= in_sample_value;
         last_ff  <= in_last_in_block;
         ch_ff    <= ch_act;
         sh_ff    <= in_frame_time;
         frem_ff  <= '0;
         dvd_ff   <= tarl_pkg::DVD_W'(blk_sat);
         drem_ff  <= '0;
         q_ff     <= '0;
      end else if (cmd.mod_step) begin
         sh_ff   <= sh_ff << tarl_pkg::STEP_BITS;
         frem_ff <= frem_in;
         if (iter_ff < tarl_pkg::ITER_W'(tarl_pkg::DIV_ITER)) begin
            dvd_ff  <= dvd_ff << tarl_pkg::STEP_BITS;
            drem_ff <= drem_in;
            q_ff    <= q_in;
         end
      end
      if (cmd.calc_t) begin
         t_ff   <= T_W'(frem_ff) * T_W'(ch_ff) + T_W'(idx_ff);
         sum_ff <= {1'b0, frame_ff} + tarl_pkg::SUM_W'(q_ff[tarl_pkg::BLK_W-1:0]);
      end
      if (cmd.reduce) begin
         addr_ff <= addr_in;
         sil_ff  <= (lwf_ff < sum_ff);
      end
      if (cmd.out_load) begin
         rsp_data_ff <= sil_ff ? '0 : ram_rdata;
         rsp_user_ff <= sil_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= tarl_pkg::CH_RESET;
         lwf_ff       <= '0;
         clr_ff       <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            chan_ff <= csr_wdata;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.load) begin
            iter_ff <= '0;
         end else if (cmd.mod_step) begin
            iter_ff <= iter_ff + tarl_pkg::ITER_W'(1);
         end
         if (cmd.access && (cmd_ff == tarl_pkg::CMD_WRITE) && last_ff) begin
            lwf_ff <= sum_ff;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign ram_addr  = cmd.clear_step ? clr_ff : addr_ff;
   assign ram_we    = cmd.clear_step || (cmd.access && (cmd_ff == tarl_pkg::CMD_WRITE));
   assign ram_re    = cmd.access && (cmd_ff == tarl_pkg::CMD_READ);
   assign ram_wdata = cmd.clear_step ? '0 : word_ff;

   tarl_ram #(
      .WIDTH (tarl_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .re    (ram_re),
      .rdata (ram_rdata)
   );

   assign status.clr_last = (clr_ff == ADDR_W'(DEPTH - 1));
   assign status.mod_last = (iter_ff == tarl_pkg::ITER_W'(tarl_pkg::MOD_ITER - 1));
   assign status.is_read  = (cmd_ff == tarl_pkg::CMD_READ);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/sv/tb_timestamped_audio_loopback_ring.sv
module tb_timestamped_audio_loopback_ring;

   localparam int RING_FRAMES_DEF       = tarl_pkg::RING_FRAMES_DEF;
   localparam int MAX_CHANNELS_DEF      = tarl_pkg::MAX_CHANNELS_DEF;
   localparam int MAX_BLOCK_SAMPLES_DEF = tarl_pkg::MAX_BLOCK_SAMPLES_DEF;
   localparam int FRAME_W               = tarl_pkg::FRAME_W;
   localparam int IDX_W                 = tarl_pkg::IDX_W;
   localparam int BLK_W                 = tarl_pkg::BLK_W;
   localparam int WORD_W                = tarl_pkg::WORD_W;
   localparam int CH_W                  = tarl_pkg::CH_W;
   localparam int REQ_TDATA_W           = tarl_pkg::REQ_TDATA_W;

   localparam int RING_DEPTH    = RING_FRAMES_DEF * MAX_CHANNELS_DEF;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 75;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_LIMIT    = 150000;

   localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

   typedef struct packed {
      logic               command;
      logic [FRAME_W-1:0] frame_time;
      logic [IDX_W-1:0]   sample_index;
      logic [BLK_W-1:0]   block_samples;
      logic [WORD_W-1:0]  sample_value;
      logic               last_in_block;
   } sample_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic              silenced;
   } readout_type;

   typedef struct packed {
      sample_type  sample;
      logic        fixed;
      readout_type fixed_result;
   } script_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = tarl_pkg::CMD_WRITE;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [WORD_W-1:0]      rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wen    = 1'b0;
   logic [CH_W-1:0]        csr_wdata  = '0;

   logic [WORD_W-1:0] ring_copy [RING_DEPTH];
   logic [63:0]       last_frame_copy;
   logic [CH_W-1:0]   channels_copy;
   readout_type       pending_reads [$];
   script_row_type    script [$];

   logic [CH_W-1:0] phase_channels [PHASES] =
      '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd3, 4'd2, 4'd7, 4'd4, 4'd6};

   int fail_count  = 0;
   int sent_items  = 0;
   int idle_cycles = 0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;
   bit quiet_tail     = 1'b0;
   bit req_calm       = 1'b0;

   timestamped_audio_loopback_ring dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .req_tlast,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .csr_wen,
      .csr_wdata
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned effective_channels(input logic [CH_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
      return raw;
   endfunction

   function automatic void add_row(input sample_type s, input bit fixed,
                                   input readout_type r);
      script_row_type row;
      row.sample       = s;
      row.fixed        = fixed;
      row.fixed_result = r;
      script = {script, row};
   endfunction

   task automatic ring_access(input sample_type s, output bit has_result,
                              output readout_type result);
      longint unsigned ch, blk, frames, addr, reach;
      ch = effective_channels(channels_copy);
      blk = s.block_samples;
      if (blk > MAX_BLOCK_SAMPLES_DEF) blk = MAX_BLOCK_SAMPLES_DEF;
      frames = blk / ch;
      addr = (s.frame_time * ch + s.sample_index) % (RING_FRAMES_DEF * ch);
      reach = s.frame_time + frames;
      has_result = (s.command == tarl_pkg::CMD_READ);
      result = '0;
      if (s.command == tarl_pkg::CMD_WRITE) begin
         ring_copy[addr] = s.sample_value;
         if (s.last_in_block) last_frame_copy = reach;
      end else if (last_frame_copy < reach) begin
         result.silenced = 1'b1;
      end else begin
         result.read_value = ring_copy[addr];
      end
   endtask

   task automatic send_sample(input sample_type s, input bit fixed = 1'b0,
                              input readout_type fixed_result = '0);
      bit          has_result;
      readout_type result;
      readout_type want_read;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({s.sample_value, s.block_samples, s.sample_index,
                                  s.frame_time});
      req_tuser  <= s.command;
      req_tlast  <= s.last_in_block;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      ring_access(s, has_result, result);
      if (has_result) begin
         want_read     = fixed ? fixed_result : result;
         pending_reads = {pending_reads, want_read};
      end
      sent_items++;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      if (!quiet_tail && !req_calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_block(input logic cmd, input logic [FRAME_W-1:0] start,
                             input int nframes, input bit drop_last);
      sample_type  s;
      int unsigned blk;
      blk = 32'(longint'(nframes) * effective_channels(channels_copy));
      for (int i = 0; i < blk; i++) begin
         s.command       = cmd;
         s.frame_time    = start;
         s.sample_index  = IDX_W'(i);
         s.block_samples = BLK_W'(blk);
         s.sample_value  = $urandom;
         s.last_in_block = (i == blk - 1) && !drop_last;
         send_sample(s);
      end
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s.command       = 1'($urandom);
      s.frame_time    = {16'($urandom), 32'($urandom)};
      s.sample_index  = IDX_W'($urandom);
      s.block_samples = BLK_W'($urandom);
      s.sample_value  = $urandom;
      s.last_in_block = 1'($urandom);
      return s;
   endfunction

   task automatic wait_drained();
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_channels(input logic [CH_W-1:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      channels_copy = value;
      csr_wen <= 1'b0;
   endtask

   initial begin : stimulus
      logic [FRAME_W-1:0] cursor;
      int                 nframes;
      int                 pick;
      int                 target;
      for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
      last_frame_copy = '0;
      channels_copy   = tarl_pkg::CH_RESET;

      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd2, 32'h0, 1'b0}, 1'b1,
              '{32'h0, 1'b1});
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd0, 32'h0, 1'b0}, 1'b1,
              '{32'h0, 1'b0});
      add_row('{tarl_pkg::CMD_READ, FRAME_MAX, 12'd4095, 13'd8191, 32'hFFFFFFFF, 1'b1},
              1'b1, '{32'h0, 1'b1});
      add_row('{tarl_pkg::CMD_WRITE, 48'd0, 12'd0, 13'd4, 32'hFFFFFFFF, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd0, 12'd1, 13'd4, 32'h00000000, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd0, 12'd2, 13'd4, 32'hA5A5A5A5, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd0, 12'd3, 13'd4, 32'h5A5A5A5A, 1'b1}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd4, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd3, 13'd4, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd1, 12'd2, 13'd4, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd4095, 13'd4, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd4096, 12'd1, 13'd2, 32'h0F0F0F0F, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd1, 13'd4, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, FRAME_MAX, 12'd4095, 13'd8191, 32'h12345678, 1'b1},
              1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, FRAME_MAX, 12'd4095, 13'd8191, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd4096, 32'h0, 1'b1}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd100, 12'd7, 13'd0, 32'hDEADBEEF, 1'b1}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd100, 12'd7, 13'd0, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd100, 12'd7, 13'd1, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd100, 12'd7, 13'd2, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_WRITE, 48'd0, 12'd0, 13'd4096, 32'h0, 1'b1}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd4096, 32'h0, 1'b0}, 1'b0, '0);
      add_row('{tarl_pkg::CMD_READ, 48'd0, 12'd0, 13'd8191, 32'h0, 1'b0}, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_sample(script[i].sample, script[i].fixed,
                                      script[i].fixed_result);

      for (int ph = 0; ph < PHASES; ph++) begin
         set_channels(phase_channels[ph]);
         if (ph == 1) long_hold_req = 1'b1;
         if (ph == PHASES - 1) quiet_tail = 1'b1;
         case ($urandom_range(0, 2))
            0: cursor = FRAME_W'($urandom_range(0, 5000));
            1: cursor = FRAME_MAX - FRAME_W'($urandom_range(0, 200));
            default: cursor = {16'($urandom), 32'($urandom)};
         endcase
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            pick    = $urandom_range(0, 9);
            nframes = $urandom_range(1, 4);
            if (pick < 5) begin
               send_block(tarl_pkg::CMD_WRITE, cursor, nframes, 1'b0);
               send_block(tarl_pkg::CMD_READ, cursor, nframes, 1'b0);
               cursor += FRAME_W'(nframes);
            end else if (pick < 7) begin
               send_block(tarl_pkg::CMD_READ, cursor - FRAME_W'($urandom_range(0, 8)),
                          nframes, 1'b0);
            end else if (pick == 7) begin
               send_block(tarl_pkg::CMD_WRITE, cursor, nframes, 1'b1);
            end else begin
               send_sample(random_sample());
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      if (fail_count == 0 && pending_reads.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : result_sink
      int hold_left;
      bit calm;
      hold_left = 0;
      calm      = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) calm = !calm;
         if (hold_left > 0) begin
            hold_left--;
         end else if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 16);
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin : result_check
      readout_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_reads.size() == 0) begin
            $error("read result with no read outstanding: read_value %h silenced %b",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_tdata !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.silenced) begin
               $error("silenced: expected %b, actual %b", want.silenced, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
